// ----- rtl/core/dwpd_pkg.sv -----
// ============================================================================
// dwpd_pkg: shared types and constants of the dual-window peak detector
// Field widths, register indexes, reset values and the request record that
// travels from the tracker lanes to the output queue.
// ============================================================================
package dwpd_pkg;

    // Field widths fixed by the stream format
    localparam int TSTAT_W    = 16;
    localparam int VAL_W      = TSTAT_W + 1;
    localparam int WIN_W      = 11;
    localparam int HALF_W     = WIN_W - 1;
    localparam int OUT_POS_W  = 20;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Position range default
    localparam int MAX_POSITIONS_DEF = 1048576;

    // Tracker value reset marker, above every 16-bit value
    localparam logic [VAL_W-1:0] INF_MARK = {1'b1, {TSTAT_W{1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_THR = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_THR  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_WIN = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_WIN  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PEAK_HGT  = 3'd4;

    // Configuration reset values
    localparam logic [WIN_W-1:0] SHORT_WIN_RST = 11'd3;
    localparam logic [WIN_W-1:0] LONG_WIN_RST  = 11'd6;

    // Output queue sizing, counted in input items
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Status flags of one tracker lane for one item
    typedef struct packed {
        logic over;
        logic emit;
    } dwpd_flags_t;

    // Results of one item, short result ahead of long result
    typedef struct packed {
        logic                 short_vld;
        logic [OUT_POS_W-1:0] short_pos;
        logic                 long_vld;
        logic [OUT_POS_W-1:0] long_pos;
    } dwpd_req_t;

endpackage

// ----- rtl/core/dwpd_lane.sv -----
// ============================================================================
// dwpd_lane: one peak tracker lane
// Follows a falling minimum, arms on a rise above peak height, follows the
// maximum, confirms on a drop above peak height from a maximum over the threshold
// and emits the peak position once more than half a window has passed.
// ============================================================================
module dwpd_lane #(
    parameter int POS_W = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic                          clear,
    input  logic                          enable,
    input  logic [dwpd_pkg::TSTAT_W-1:0]  cur,
    input  logic [POS_W-1:0]              pos,
    input  logic [dwpd_pkg::TSTAT_W-1:0]  thr,
    input  logic [dwpd_pkg::HALF_W-1:0]   half_win,
    input  logic [dwpd_pkg::TSTAT_W-1:0]  min_step,
    output dwpd_pkg::dwpd_flags_t         flags,
    output logic [POS_W-1:0]              peak_pos
);
    import dwpd_pkg::*;

    logic [VAL_W-1:0] val_reg,   val_next;
    logic [POS_W-1:0] ppos_reg,  ppos_next;
    logic             armed_reg, armed_next;
    logic             conf_reg,  conf_next;

    logic [VAL_W-1:0] base_val;
    logic [POS_W-1:0] base_ppos;
    logic             base_armed;
    logic             base_conf;
    logic [VAL_W-1:0] cur_ext;
    logic [VAL_W:0]   rise_lim;
    logic [VAL_W-1:0] fall_lim;
    logic [VAL_W-1:0] val_trk;
    logic [POS_W-1:0] ppos_trk;
    logic             armed_trk;
    logic             conf_trk;
    logic             over_trk;
    logic             emit_trk;
    logic [POS_W-1:0] pos_gap;

    // State as seen by this item, after a clear request
    always_comb begin
        if (clear) begin
            base_val   = INF_MARK;
            base_ppos  = '0;
            base_armed = 1'b0;
            base_conf  = 1'b0;
        end else begin
            base_val   = val_reg;
            base_ppos  = ppos_reg;
            base_armed = armed_reg;
            base_conf  = conf_reg;
        end
    end

    assign cur_ext  = {1'b0, cur};
    assign rise_lim = {1'b0, base_val} + (VAL_W + 1)'(min_step);
    assign fall_lim = cur_ext + VAL_W'(min_step);

    // Tracker update for one value
    always_comb begin
        val_trk   = base_val;
        ppos_trk  = base_ppos;
        armed_trk = base_armed;
        conf_trk  = base_conf;
        over_trk  = 1'b0;
        emit_trk  = 1'b0;
        pos_gap   = '0;
        if (!base_armed) begin
            if (cur_ext < base_val) begin
                val_trk = cur_ext;
            end else if ({1'b0, cur_ext} > rise_lim) begin
                val_trk   = cur_ext;
                ppos_trk  = pos;
                armed_trk = 1'b1;
            end
        end else begin
            if (cur_ext > base_val) begin
                val_trk  = cur_ext;
                ppos_trk = pos;
            end
            over_trk = (val_trk > {1'b0, thr});
            if (over_trk && (val_trk > fall_lim)) begin
                conf_trk = 1'b1;
            end
            pos_gap = pos - ppos_trk;
            if (conf_trk && (pos_gap > POS_W'(half_win))) begin
                emit_trk  = 1'b1;
                armed_trk = 1'b0;
                val_trk   = cur_ext;
                conf_trk  = 1'b0;
            end
        end
    end

    // Skipped items keep the state as seen by this item, cleared after a clear request
    always_comb begin
        if (enable) begin
            val_next   = val_trk;
            ppos_next  = ppos_trk;
            armed_next = armed_trk;
            conf_next  = conf_trk;
        end else begin
            val_next   = base_val;
            ppos_next  = base_ppos;
            armed_next = base_armed;
            conf_next  = base_conf;
        end
    end

    // The peak position serves both the mask span and the emitted result.
    assign flags.over = enable && over_trk;
    assign flags.emit = enable && emit_trk;
    assign peak_pos   = ppos_trk;

    // Tracker state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg   <= INF_MARK;
            ppos_reg  <= '0;
            armed_reg <= 1'b0;
            conf_reg  <= 1'b0;
        end else if (accept) begin
            val_reg   <= val_next;
            ppos_reg  <= ppos_next;
            armed_reg <= armed_next;
            conf_reg  <= conf_next;
        end
    end

endmodule

// ----- rtl/core/dwpd_outq.sv -----
// ============================================================================
// dwpd_outq: result merge and output queue
// Holds the results of up to four items and sends them one per request,
// the short result ahead of the long one, with tlast on the final one.
// ============================================================================
module dwpd_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  dwpd_pkg::dwpd_req_t push_req,
    output logic                in_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // [19:0] peak_position, [23:20] zero
    output logic                m_tuser,   // [0] from_long
    output logic                m_tlast    // last_of_run
);
    import dwpd_pkg::*;

    dwpd_req_t           q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg,    cnt_next;
    logic                first_done_reg, first_done_next;
    dwpd_req_t           head;
    logic                sel_long;
    logic                out_take;
    logic                pop;
    logic                do_push;

    assign in_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign do_push  = push && in_ready;
    assign head     = q_mem[rd_ptr_reg];

    // Pick the short result first when both are present
    assign sel_long = !head.short_vld || first_done_reg;
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {4'b0, (sel_long ? head.long_pos : head.short_pos)};
    assign m_tuser  = sel_long;
    assign m_tlast  = sel_long || !head.long_vld;

    assign out_take = m_tvalid && m_tready;
    assign pop      = out_take && m_tlast;

    // Pointer, count and sub-result bookkeeping
    always_comb begin
        wr_ptr_next     = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next     = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next        = cnt_reg + QCNT_W'(do_push) - QCNT_W'(pop);
        first_done_next = first_done_reg;
        if (out_take) begin
            first_done_next = !m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
            first_done_reg <= 1'b0;
        end else begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            cnt_reg        <= cnt_next;
            first_done_reg <= first_done_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_mem[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ----- rtl/core/dual_window_peak_detector_top.sv -----
// ============================================================================
// dual_window_peak_detector_top: dual-window t-statistic peak detector
// Two tracker lanes, short and long window, find boundary peaks in a stream
// of t-statistic pairs; a merge queue sends the peak positions out.
// ============================================================================
// The block takes one t-statistic pair per clock cycle while s_tready is high and
// updates both tracker lanes in that same cycle, so the short lane's masking of the
// long lane acts within the item. Each item gives zero, one or two peak positions,
// which can appear on the result stream from the cycle after the item is accepted;
// the output queue holds the results of four items and sends one result per cycle
// while m_tready is high, an item with two results as two transfers. s_tready
// drops only while those four item slots are full. The first item of a read
// carries first_of_read in s_tuser and is position 0; positions stop at MAX_POSITIONS-1.
module dual_window_peak_detector_top #(
    parameter int MAX_POSITIONS = dwpd_pkg::MAX_POSITIONS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [15:0] tstat_short, [31:16] tstat_long
    input  logic                            s_tuser,   // [0] first_of_read
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // [19:0] peak_position, [23:20] zero
    output logic                            m_tuser,   // [0] from_long
    output logic                            m_tlast,   // last_of_run
    // Configuration write port
    input  logic                            cfg_wr_en,
    input  logic [dwpd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dwpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import dwpd_pkg::*;

    localparam int POS_W  = $clog2(MAX_POSITIONS);
    localparam int MASK_W = ((POS_W > WIN_W) ? POS_W : WIN_W) + 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_POSITIONS - 1);

    logic [TSTAT_W-1:0] short_thr_reg;
    logic [TSTAT_W-1:0] long_thr_reg;
    logic [WIN_W-1:0]   short_win_reg;
    logic [WIN_W-1:0]   long_win_reg;
    logic [TSTAT_W-1:0] peak_hgt_reg;

    logic [POS_W-1:0]   pos_cnt_reg, pos_cnt_next;
    logic [MASK_W-1:0]  masked_reg,  masked_next;

    logic               accept;
    logic               first;
    logic [POS_W-1:0]   pos;
    logic               pos_live;
    logic [MASK_W-1:0]  masked_base;
    logic               long_clear;
    logic               long_en;

    dwpd_flags_t        short_flags;
    dwpd_flags_t        long_flags;
    logic [POS_W-1:0]   short_peak_pos;
    logic [POS_W-1:0]   long_peak_pos;
    dwpd_req_t          req;
    logic               q_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_thr_reg <= '0;
            long_thr_reg  <= '0;
            short_win_reg <= SHORT_WIN_RST;
            long_win_reg  <= LONG_WIN_RST;
            peak_hgt_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SHORT_THR: short_thr_reg <= cfg_wdata;
                REG_LONG_THR:  long_thr_reg  <= cfg_wdata;
                REG_SHORT_WIN: short_win_reg <= cfg_wdata[WIN_W-1:0];
                REG_LONG_WIN:  long_win_reg  <= cfg_wdata[WIN_W-1:0];
                REG_PEAK_HGT:  peak_hgt_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = q_ready;
    assign accept   = s_tvalid && s_tready;
    assign first    = s_tuser;

    // Position of this item and saturating counter
    assign pos          = first ? '0 : pos_cnt_reg;
    assign pos_live     = (pos != '0);
    assign pos_cnt_next = (pos < POS_LAST) ? pos + 1'b1 : pos;

    // Short lane
    dwpd_lane #(
        .POS_W(POS_W)
    ) u_short (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .clear       (first),
        .enable      (pos_live),
        .cur         (s_tdata[15:0]),
        .pos         (pos),
        .thr         (short_thr_reg),
        .half_win    (short_win_reg[WIN_W-1:1]),
        .min_step    (peak_hgt_reg),
        .flags       (short_flags),
        .peak_pos    (short_peak_pos)
    );

    // Long lane masking by a strong short peak
    assign masked_base = first ? '0 : masked_reg;
    assign masked_next = short_flags.over
                       ? MASK_W'(short_peak_pos) + MASK_W'(short_win_reg)
                       : masked_base;
    assign long_clear  = first || short_flags.over;
    assign long_en     = pos_live && (masked_next < MASK_W'(pos));

    // Long lane
    dwpd_lane #(
        .POS_W(POS_W)
    ) u_long (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .clear       (long_clear),
        .enable      (long_en),
        .cur         (s_tdata[31:16]),
        .pos         (pos),
        .thr         (long_thr_reg),
        .half_win    (long_win_reg[WIN_W-1:1]),
        .min_step    (peak_hgt_reg),
        .flags       (long_flags),
        .peak_pos    (long_peak_pos)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_cnt_reg <= '0;
            masked_reg  <= '0;
        end else if (accept) begin
            pos_cnt_reg <= pos_cnt_next;
            masked_reg  <= masked_next;
        end
    end

    // Merge the lane results of this item
    assign req.short_vld = short_flags.emit;
    assign req.short_pos = OUT_POS_W'(short_peak_pos);
    assign req.long_vld  = long_flags.emit;
    assign req.long_pos  = OUT_POS_W'(long_peak_pos);

    dwpd_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept && (short_flags.emit || long_flags.emit)),
        .push_req (req),
        .in_ready (q_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // A full queue always has a result to offer
    a_full_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // Neither lane acts on position zero
    a_no_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && first) |-> (!short_flags.emit && !long_flags.emit
                               && !long_flags.over))
        else $error("lane active at position zero");

    // A masking short peak leaves the long lane unarmed for this item
    a_mask_no_long_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        short_flags.over |-> !long_flags.emit)
        else $error("long lane emitted while masked");

    // The item after the start of a read is position one
    a_restart_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && first) |=> (pos_cnt_reg == POS_W'(1)))
        else $error("position counter not restarted");

endmodule
